// File: design/scalar_kalman_trajectory_smoother_macros.svh
// Assertion macros for the trajectory smoother top module.
`ifndef SCALAR_KALMAN_TRAJECTORY_SMOOTHER_MACROS_SVH
`define SCALAR_KALMAN_TRAJECTORY_SMOOTHER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SKT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/skt_pkg.sv
// Shared types and constants for the scalar Kalman trajectory smoother.
package skt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CHANNELS      = 3;
  localparam int CH_W          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int REG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int VAR_W     = 32;
  localparam int DEN_W     = VAR_W + 1;
  localparam int TOT_W     = 48;
  localparam int OUT_W     = 32;
  localparam int MUL_A_W   = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 2'd1;

  // Register reset codes, unsigned Q8.16 for the default FRAC_BITS
  localparam logic [REG_W-1:0] PROC_NOISE_RST = 24'd262;
  localparam logic [REG_W-1:0] MEAS_NOISE_RST = 24'd32768;

  typedef struct packed {
    logic signed [OUT_W-1:0] motion_angle;
    logic signed [OUT_W-1:0] motion_x;
    logic signed [OUT_W-1:0] motion_y;
  } motion_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] fix_angle;
    logic signed [OUT_W-1:0] fix_x;
    logic signed [OUT_W-1:0] fix_y;
    logic signed [OUT_W-1:0] steady_angle;
    logic signed [OUT_W-1:0] steady_x;
    logic signed [OUT_W-1:0] steady_y;
  } result_t;

  // Multiply-accumulate control from the sequencer
  typedef struct packed {
    logic mul_en;     // capture a*b into the product register
    logic acc_en;     // fold the product register into the accumulator
    logic acc_first;  // start a new sum with the rounding half
    logic acc_hi;     // product is shifted up by 32 bits before it is added
  } mac_ctl_t;

endpackage

// File: design/skt_div.sv
// Restoring divider for the Kalman gain, one quotient bit per cycle.
module skt_div import skt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [VAR_W-1:0]     num,
  input  logic [DEN_W-1:0]     den,
  output logic                 done,
  output logic [FRAC_BITS:0]   quo
);

  localparam int K_W   = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam int REM_W = DEN_W + 1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic             den_zero;
  logic [K_W-1:0]   q;
  logic             fits;
  logic [REM_W-1:0] rem_sub;

  // One trial subtraction per cycle
  assign fits    = rem >= {1'b0, den_r};
  assign rem_sub = fits ? rem - {1'b0, den_r} : rem;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(FRAC_BITS));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(FRAC_BITS)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= REM_W'(num);
      den_r    <= den;
      den_zero <= (den == '0);
      q        <= '0;
    end else if (busy) begin
      q   <= {q[K_W-2:0], fits};
      rem <= {rem_sub[REM_W-2:0], 1'b0};
    end
  end

  // Zero denominator holds the estimate: gain 0
  assign quo = den_zero ? '0 : q;

endmodule

// File: design/skt_mac.sv
// Shared multiplier with a registered product and a rounding accumulator.
module skt_mac import skt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  mac_ctl_t                  ctl,
  input  logic [MUL_A_W-1:0]        op_a,
  input  logic [FRAC_BITS:0]        op_b,
  output logic [FRAC_BITS+49:0]     acc
);

  localparam int K_W    = FRAC_BITS + 1;
  localparam int PROD_W = MUL_A_W + K_W;
  localparam int ACC_W  = FRAC_BITS + 50;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  addend;

  // Product stage
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= PROD_W'(op_a) * PROD_W'(op_b);
    end
  end

  // Upper-half products weigh 2^32
  assign addend = ctl.acc_hi ? (ACC_W'(prod) << MUL_A_W) : ACC_W'(prod);

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      acc <= ctl.acc_first ? HALF + addend : acc + addend;
    end
  end

endmodule

// File: design/scalar_kalman_trajectory_smoother.sv
// One beat at a time: a new beat is taken only once the previous one is through. The gain divider takes
// FRAC_BITS + 1 steps; each channel runs the difference, low multiply, high multiply, accumulate and
// update states, the multiply and accumulate states in the shared multiplier.
// motion_stall is high from acceptance until the result is loaded into the output register.
// Reset (rst, synchronous): totals zero, error variance 1.0, first-item flag clear,
// noise registers at their Q8.16 defaults, no result pending.
`include "scalar_kalman_trajectory_smoother_macros.svh"

module scalar_kalman_trajectory_smoother import skt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 motion_valid,
  output logic                 motion_stall,
  input  motion_t              motion,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  localparam int K_W   = FRAC_BITS + 1;
  localparam int ACC_W = FRAC_BITS + 50;
  localparam logic [K_W-1:0]   ONE_FX  = K_W'(1) << FRAC_BITS;
  localparam logic [VAR_W-1:0] VAR_RST = VAR_W'(1) << FRAC_BITS;

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b000000000001,
    ST_PRED    = 12'b000000000010,
    ST_DIV     = 12'b000000000100,
    ST_CH_DIFF = 12'b000000001000,
    ST_CH_MLO  = 12'b000000010000,
    ST_CH_MHI  = 12'b000000100000,
    ST_CH_ACC  = 12'b000001000000,
    ST_CH_UPD  = 12'b000010000000,
    ST_VAR_MUL = 12'b000100000000,
    ST_VAR_ACC = 12'b001000000000,
    ST_VAR_UPD = 12'b010000000000,
    ST_DONE    = 12'b100000000000
  } state_t;

  state_t state;

  // Configuration and filter state
  logic [REG_W-1:0] process_noise;
  logic [REG_W-1:0] measure_noise;
  logic [TOT_W-1:0] raw_total    [CHANNELS];
  logic [TOT_W-1:0] smooth_total [CHANNELS];
  logic [VAR_W-1:0] error_variance;
  logic             seen_first;

  // Per-item working registers
  logic [OUT_W-1:0] meas     [CHANNELS];
  logic [OUT_W-1:0] fix_r    [CHANNELS];
  logic [OUT_W-1:0] steady_r [CHANNELS];
  logic [VAR_W-1:0] p_pred;
  logic [K_W-1:0]   gain;
  logic [TOT_W-1:0] mag;
  logic             neg;
  logic [CH_W-1:0]  ch;

  // Combinational datapath
  logic [VAR_W:0]     p_sum;
  logic [VAR_W-1:0]   p_pred_c;
  logic [DEN_W-1:0]   den_c;
  logic [TOT_W:0]     meas_ext;
  logic [TOT_W:0]     raw_sum;
  logic [TOT_W-1:0]   raw_new;
  logic [TOT_W:0]     diff;
  logic [TOT_W:0]     diff_abs;
  logic [TOT_W-1:0]   gain_q;
  logic [TOT_W-1:0]   smooth_new;
  logic [TOT_W:0]     fix_d;
  logic [OUT_W-1:0]   fix_c;
  logic [TOT_W:0]     steady_d;
  logic [OUT_W-1:0]   steady_c;

  logic               div_done;
  logic [K_W-1:0]     div_quo;
  mac_ctl_t           mac_ctl;
  logic [MUL_A_W-1:0] mac_a;
  logic [K_W-1:0]     mac_b;
  logic [ACC_W-1:0]   mac_acc;

  function automatic logic [TOT_W-1:0] sat_tot(input logic [TOT_W:0] s);
    if (s[TOT_W] != s[TOT_W-1]) begin
      return s[TOT_W] ? {1'b1, {(TOT_W-1){1'b0}}} : {1'b0, {(TOT_W-1){1'b1}}};
    end
    return s[TOT_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic [TOT_W:0] s);
    if ((&s[TOT_W:OUT_W-1]) || !(|s[TOT_W:OUT_W-1])) begin
      return s[OUT_W-1:0];
    end
    return s[TOT_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
  endfunction

  assign cfg_ready    = 1'b1;
  assign motion_stall = (state != ST_IDLE);

  // Predicted variance, saturated to 32 bits, and the gain denominator
  assign p_sum    = {1'b0, error_variance} + (VAR_W + 1)'(process_noise);
  assign p_pred_c = p_sum[VAR_W] ? '1 : p_sum[VAR_W-1:0];
  assign den_c    = {1'b0, p_pred_c} + DEN_W'(measure_noise);

  // Raw total update and innovation for the current channel
  assign meas_ext = {{(TOT_W + 1 - OUT_W){meas[ch][OUT_W-1]}}, meas[ch]};
  assign raw_sum  = {raw_total[ch][TOT_W-1], raw_total[ch]} + meas_ext;
  assign raw_new  = sat_tot(raw_sum);
  assign diff     = {raw_new[TOT_W-1], raw_new}
                  - {smooth_total[ch][TOT_W-1], smooth_total[ch]};
  assign diff_abs = diff[TOT_W] ? (~diff + 1'b1) : diff;

  // Rounded gain step; the accumulator already holds the half
  assign gain_q     = mac_acc[FRAC_BITS+TOT_W-1:FRAC_BITS];
  assign smooth_new = neg ? smooth_total[ch] - gain_q : smooth_total[ch] + gain_q;

  // Correction and corrected motion (raw_total[ch] is already updated here)
  assign fix_d    = {smooth_new[TOT_W-1], smooth_new}
                  - {raw_total[ch][TOT_W-1], raw_total[ch]};
  assign fix_c    = seen_first ? sat_out(fix_d) : '0;
  assign steady_d = meas_ext + {{(TOT_W + 1 - OUT_W){fix_c[OUT_W-1]}}, fix_c};
  assign steady_c = sat_out(steady_d);

  // Shared multiplier schedule
  always_comb begin
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = gain;
    unique case (state)
      ST_CH_MLO: begin
        mac_ctl.mul_en = 1'b1;
        mac_a          = mag[MUL_A_W-1:0];
      end
      ST_CH_MHI: begin
        mac_ctl.mul_en    = 1'b1;
        mac_ctl.acc_en    = 1'b1;
        mac_ctl.acc_first = 1'b1;
        mac_a             = MUL_A_W'(mag[TOT_W-1:MUL_A_W]);
      end
      ST_CH_ACC: begin
        mac_ctl.acc_en = 1'b1;
        mac_ctl.acc_hi = 1'b1;
      end
      ST_VAR_MUL: begin
        mac_ctl.mul_en = 1'b1;
        mac_a          = p_pred;
        mac_b          = ONE_FX - gain;
      end
      ST_VAR_ACC: begin
        mac_ctl.acc_en    = 1'b1;
        mac_ctl.acc_first = 1'b1;
      end
      default: begin
      end
    endcase
  end

  skt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_PRED),
    .num   (p_pred_c),
    .den   (den_c),
    .done  (div_done),
    .quo   (div_quo)
  );

  skt_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (mac_acc)
  );

  // Sequencer and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      process_noise  <= PROC_NOISE_RST;
      measure_noise  <= MEAS_NOISE_RST;
      error_variance <= VAR_RST;
      seen_first     <= 1'b0;
      result_valid   <= 1'b0;
      ch             <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        raw_total[i]    <= '0;
        smooth_total[i] <= '0;
      end
    end else begin
      // Noise registers
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PROC_NOISE: process_noise <= cfg_data;
          REG_MEAS_NOISE: measure_noise <= cfg_data;
          default: begin
          end
        endcase
      end

      // Output register: load a new beat or drop the one taken
      if (state == ST_DONE && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (motion_valid) begin
            state <= ST_PRED;
          end
        end
        ST_PRED: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            ch    <= '0;
            state <= ST_CH_DIFF;
          end
        end
        ST_CH_DIFF: begin
          raw_total[ch] <= raw_new;
          state         <= ST_CH_MLO;
        end
        ST_CH_MLO: state <= ST_CH_MHI;
        ST_CH_MHI: state <= ST_CH_ACC;
        ST_CH_ACC: state <= ST_CH_UPD;
        ST_CH_UPD: begin
          smooth_total[ch] <= smooth_new;
          if (ch == CH_W'(CHANNELS - 1)) begin
            state <= ST_VAR_MUL;
          end else begin
            ch    <= ch + 1'b1;
            state <= ST_CH_DIFF;
          end
        end
        ST_VAR_MUL: state <= ST_VAR_ACC;
        ST_VAR_ACC: state <= ST_VAR_UPD;
        ST_VAR_UPD: begin
          error_variance <= mac_acc[FRAC_BITS+VAR_W-1:FRAC_BITS];
          seen_first     <= 1'b1;
          state          <= ST_DONE;
        end
        ST_DONE: begin
          if (!result_valid || !result_stall) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && motion_valid) begin
      meas[0] <= motion.motion_angle;
      meas[1] <= motion.motion_x;
      meas[2] <= motion.motion_y;
    end
    if (state == ST_PRED) begin
      p_pred <= p_pred_c;
    end
    if (state == ST_DIV && div_done) begin
      gain <= div_quo;
    end
    if (state == ST_CH_DIFF) begin
      mag <= diff_abs[TOT_W-1:0];
      neg <= diff[TOT_W];
    end
    if (state == ST_CH_UPD) begin
      fix_r[ch]    <= fix_c;
      steady_r[ch] <= steady_c;
    end
    if (state == ST_DONE && (!result_valid || !result_stall)) begin
      result.fix_angle    <= fix_r[0];
      result.fix_x        <= fix_r[1];
      result.fix_y        <= fix_r[2];
      result.steady_angle <= steady_r[0];
      result.steady_x     <= steady_r[1];
      result.steady_y     <= steady_r[2];
    end
  end

  `SKT_ASSERT_NEXT(a_accept_starts, motion_valid && !motion_stall, state == ST_PRED, "accepted beat did not start the prediction step")
  `SKT_ASSERT_NOW(a_gain_bounded, state == ST_VAR_MUL, gain <= ONE_FX, "Kalman gain above one")
  `SKT_ASSERT_NOW(a_result_from_done, $rose(result_valid), $past(state) == ST_DONE, "result raised outside the completion step")
  `SKT_ASSERT_NOW(a_channel_range, state == ST_CH_UPD, ch < CH_W'(CHANNELS), "channel index out of range")

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench: trajectory smoother against a fixed-point Kalman predictor.
module tb;
  import skt_pkg::*;

  localparam int FRAC         = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 2 * (FRAC + 5 * CHANNELS + 8);
  localparam int MAX_REPORTS  = 10;
  localparam int HOLD_CYCLES  = 400;

  localparam logic [REG_W-1:0]     NOISE_MAX   = '1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam longint TOTAL_MAX = (longint'(1) <<< 47) - 1;
  localparam longint TOTAL_MIN = -(longint'(1) <<< 47);
  localparam longint WORD_MAX  = 64'sd2147483647;
  localparam longint WORD_MIN  = -64'sd2147483648;

  localparam longint unsigned GAIN_ONE  = 64'd1 << FRAC;
  localparam longint unsigned HALF_LSB  = 64'd1 << (FRAC - 1);
  localparam longint unsigned FRAC_MASK = GAIN_ONE - 1;

  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 motion_valid = 1'b0;
  logic                 motion_stall;
  motion_t              motion = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;

  // Predictor state, mirrors the block's registers
  logic [REG_W-1:0] q_noise = PROC_NOISE_RST;
  logic [REG_W-1:0] r_noise = MEAS_NOISE_RST;
  longint           raw_traj [CHANNELS] = '{default: 0};
  longint           smooth_traj [CHANNELS] = '{default: 0};
  longint unsigned  err_var = GAIN_ONE;
  bit               have_prior = 1'b0;
  result_t          pending_fixes [$];

  int sender_idle_pct = 0;
  int recv_idle_pct   = 0;
  int hold_request    = 0;
  int hold_left       = 0;
  int cycle_count     = 0;
  int beats_sent      = 0;
  int results_seen    = 0;
  int cfg_writes      = 0;
  int mismatch_count  = 0;
  int stray_results   = 0;

  scalar_kalman_trajectory_smoother dut (
    .clk          (clk),
    .rst          (rst),
    .motion_valid (motion_valid),
    .motion_stall (motion_stall),
    .motion       (motion),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_fixes.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint clamp64(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // diff * gain / 2^FRAC, rounded half away from zero
  function automatic longint apply_gain(longint diff, longint unsigned gain);
    longint unsigned mag;
    longint unsigned prod;
    mag = (diff < 0) ? -diff : diff;
    prod = (mag >> FRAC) * gain + (((mag & FRAC_MASK) * gain + HALF_LSB) >> FRAC);
    return (diff < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  // One filter step: update totals, gain and variance, return the corrections
  function automatic result_t kalman_correct(motion_t m);
    longint unsigned p_pred;
    longint unsigned den;
    longint unsigned gain;
    longint          meas [CHANNELS];
    longint          fix [CHANNELS];
    longint          steady [CHANNELS];
    result_t         r;
    int              c;
    meas[0] = m.motion_angle;
    meas[1] = m.motion_x;
    meas[2] = m.motion_y;
    p_pred = err_var + q_noise;
    if (p_pred > 64'hFFFF_FFFF) p_pred = 64'hFFFF_FFFF;
    den = p_pred + r_noise;
    gain = (den == 0) ? 64'd0 : (p_pred << FRAC) / den;
    for (c = 0; c < CHANNELS; c++) begin
      raw_traj[c] = clamp64(raw_traj[c] + meas[c], TOTAL_MIN, TOTAL_MAX);
      smooth_traj[c] += apply_gain(raw_traj[c] - smooth_traj[c], gain);
    end
    err_var = (((GAIN_ONE - gain) * p_pred + HALF_LSB) >> FRAC) & 64'hFFFF_FFFF;
    for (c = 0; c < CHANNELS; c++) begin
      fix[c] = have_prior ? clamp64(smooth_traj[c] - raw_traj[c], WORD_MIN, WORD_MAX) : 0;
      steady[c] = clamp64(meas[c] + fix[c], WORD_MIN, WORD_MAX);
    end
    have_prior = 1'b1;
    r.fix_angle    = fix[0][31:0];
    r.fix_x        = fix[1][31:0];
    r.fix_y        = fix[2][31:0];
    r.steady_angle = steady[0][31:0];
    r.steady_x     = steady[1][31:0];
    r.steady_y     = steady[2][31:0];
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("mismatch on %s at result %0d: expected %h, got %h",
                 name, results_seen, want, got);
    end
  endfunction

  // Result checker
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (pending_fixes.size() == 0) begin
        stray_results++;
        if (stray_results <= MAX_REPORTS) $display("unexpected result beat %h", result);
      end else begin
        want = pending_fixes.pop_front();
        compare_field("fix_angle", want.fix_angle, result.fix_angle);
        compare_field("fix_x", want.fix_x, result.fix_x);
        compare_field("fix_y", want.fix_y, result.fix_y);
        compare_field("steady_angle", want.steady_angle, result.steady_angle);
        compare_field("steady_x", want.steady_x, result.steady_x);
        compare_field("steady_y", want.steady_y, result.steady_y);
      end
    end
  end

  // Result side: random stall, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Offer one motion beat; returns on the falling edge after acceptance
  task automatic send_motion(motion_t m);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      motion_valid <= 1'b0;
      @(negedge clk);
    end
    motion_valid <= 1'b1;
    motion <= m;
    @(posedge clk);
    while (motion_stall) @(posedge clk);
    pending_fixes = {pending_fixes, kalman_correct(m)};
    beats_sent++;
    @(negedge clk);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    motion_valid <= 1'b0;
    do @(negedge clk); while (pending_fixes.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val, bit last_beat);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PROC_NOISE: q_noise = val;
      REG_MEAS_NOISE: r_noise = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    if (last_beat) cfg_valid <= 1'b0;
  endtask

  task automatic set_noise(logic [REG_W-1:0] q, logic [REG_W-1:0] r);
    write_reg(REG_PROC_NOISE, q, 1'b0);
    write_reg(REG_MEAS_NOISE, r, 1'b1);
  endtask

  function automatic logic [REG_W-1:0] pick_noise();
    logic [31:0] draw;
    draw = $urandom();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return NOISE_MAX;
      2: return PROC_NOISE_RST;
      3: return MEAS_NOISE_RST;
      4: return draw[REG_W-1:0];
      default: return REG_W'(draw[17:0]);
    endcase
  endfunction

  // Mostly realistic small motion, with full-range words and rail values mixed in
  function automatic logic signed [31:0] random_word();
    logic [31:0] draw;
    draw = $urandom();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2, 3: return draw;
      default: return {{11{draw[20]}}, draw[20:0]};
    endcase
  endfunction

  function automatic motion_t random_motion();
    return motion_t'{random_word(), random_word(), random_word()};
  endfunction

  // Default registers out of reset; first beat must carry zero corrections
  task automatic test_first_item();
    send_motion(motion_t'{S_MAX, S_MIN, -32'sd1});
    send_motion(motion_t'{32'sd0, 32'sd1, -32'sd1});
    send_motion(motion_t'{32'sd65536, -32'sd65536, 32'sd0});
    send_motion(motion_t'{-32'sd3277, 32'sd200000, 32'sh5555_5555});
    drain_results();
  endtask

  // R = 0 drives the variance to zero; with Q = 0 too the gain falls to zero
  task automatic test_zero_noise();
    set_noise('0, '0);
    send_motion(motion_t'{32'sd1000, -32'sd2000, 32'sd3000});
    send_motion(motion_t'{-32'sd70000, 32'sd70000, 32'sh2AAA_AAAA});
    send_motion(motion_t'{32'sd5, 32'sd0, -32'sd5});
    send_motion(motion_t'{32'sd123456, -32'sd654321, 32'sd1});
    drain_results();
  endtask

  // Unused indexes must not land in either register; then unit gain
  task automatic test_gain_extremes();
    write_reg(REG_SPARE_2, NOISE_MAX, 1'b0);
    write_reg(REG_SPARE_3, NOISE_MAX, 1'b1);
    send_motion(motion_t'{32'sd40000, -32'sd40000, 32'sd77});
    send_motion(motion_t'{-32'sd9, 32'sd9, 32'sd0});
    drain_results();
    set_noise(NOISE_MAX, '0);
    send_motion(motion_t'{32'sd100000, 32'sd200000, -32'sd300000});
    send_motion(motion_t'{S_MAX, S_MIN, 32'sd0});
    send_motion(motion_t'{-32'sd1, 32'sd1, S_MAX});
    drain_results();
  endtask

  // Heavy smoothing lets the totals run away so fix and steady hit both rails
  task automatic test_output_saturation();
    set_noise('0, NOISE_MAX);
    repeat (3) send_motion(motion_t'{S_MAX, S_MIN, S_MAX});
    send_motion(motion_t'{S_MIN, S_MAX, S_MIN});
    repeat (6) send_motion(motion_t'{S_MIN, S_MAX, S_MIN});
    send_motion(motion_t'{S_MAX, S_MIN, S_MAX});
    drain_results();
  endtask

  // Long output hold while beats keep coming, so the input side backs up
  task automatic test_output_backpressure();
    set_noise(PROC_NOISE_RST, MEAS_NOISE_RST);
    hold_request = HOLD_CYCLES;
    repeat (6) send_motion(random_motion());
    drain_results();
  endtask

  // Random beats in chunks, registers re-drawn between chunks
  task automatic test_random_stream(int n_items, int send_pct, int recv_pct);
    int left;
    int chunk;
    sender_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    left = n_items;
    while (left > 0) begin
      chunk = $urandom_range(40, 120);
      if (chunk > left) chunk = left;
      set_noise(pick_noise(), pick_noise());
      repeat (chunk) send_motion(random_motion());
      drain_results();
      left -= chunk;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_first_item();
    test_zero_noise();
    test_gain_extremes();
    test_output_saturation();
    test_output_backpressure();
    test_random_stream(410, 19, 73);
    test_random_stream(410, 73, 19);
    test_random_stream(410, 0, 0);

    while (pending_fixes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d motion beats, checked %0d results over %0d register writes.",
             beats_sent, results_seen, cfg_writes);
    $display("Covered first frame, zero and unit gain, rail saturation, idle mixes, long hold.");
    if (mismatch_count == 0 && stray_results == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: scalar_kalman_trajectory_smoother.f
+incdir+design
design/skt_pkg.sv
design/skt_div.sv
design/skt_mac.sv
design/scalar_kalman_trajectory_smoother.sv
tb/sv/tb.sv
